>>> design/assert_macros.svh
// Assertion macros used by the header parser FSM.
// Standalone; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge, skipped while reset is held.
`define HHLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HHLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HHLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HHLP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/hhlp_pkg.sv
// Shared types and constants for the HTTP header line parser.
// No dependencies; used by every module of the block.
package hhlp_pkg;

	// Register map
	localparam int CfgAddrW = 2;
	localparam logic [CfgAddrW-1:0] ADDR_MAX_VALUE_OFFSET = 2'd0;

	localparam int OffW = 12;
	localparam logic [OffW-1:0] MAX_VALUE_OFFSET_RST = 12'd255;

	// Byte roles
	localparam logic [1:0] ROLE_NONE  = 2'd0;
	localparam logic [1:0] ROLE_KEY   = 2'd1;
	localparam logic [1:0] ROLE_VALUE = 2'd2;

	// Error kinds
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_KEY_BREAK = 3'd1;
	localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
	localparam logic [2:0] ERR_CR_NO_LF  = 3'd4;
	localparam logic [2:0] ERR_END_CR    = 3'd5;

	// Characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Tag of one byte
	typedef struct packed {
		logic [1:0] role;
		logic       key_done;
		logic       field_done;
		logic       headers_done;
		logic       parse_error;
		logic [2:0] error_kind;
	} hhlp_result_t;

endpackage

>>> design/hhlp_cfg.sv
// APB register block of the header parser: holds max_value_offset.
// Depends on hhlp_pkg.
module hhlp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hhlp_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [hhlp_pkg::OffW-1:0]    max_value_offset
);
	import hhlp_pkg::*;

	logic [OffW-1:0] max_off_q;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_VALUE_OFFSET);

	// Capture the limit on a completed write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_off_q <= MAX_VALUE_OFFSET_RST;
		end else if (wr_en) begin
			max_off_q <= pwdata[OffW-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MAX_VALUE_OFFSET) begin
			prdata = {{(32-OffW){1'b0}}, max_off_q};
		end
	end

	assign max_value_offset = max_off_q;

endmodule

>>> design/hhlp_fsm.sv
// Parse state machine: phase and value offset, plus the per-byte tag logic.
// Depends on hhlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hhlp_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [7:0]                data_byte,
	input  logic                      restart,
	input  logic [hhlp_pkg::OffW-1:0] max_value_offset,
	output hhlp_pkg::hhlp_result_t    result
);
	import hhlp_pkg::*;

	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_KEY    = 4'd1;
	localparam logic [3:0] PH_COLON  = 4'd2;
	localparam logic [3:0] PH_SPACE  = 4'd3;
	localparam logic [3:0] PH_VALUE  = 4'd4;
	localparam logic [3:0] PH_CR     = 4'd5;
	localparam logic [3:0] PH_LF     = 4'd6;
	localparam logic [3:0] PH_END_CR = 4'd7;
	localparam logic [3:0] PH_DONE   = 4'd8;
	localparam logic [3:0] PH_ERROR  = 4'd9;

	logic [3:0]      phase_q;
	logic [OffW-1:0] value_offset_q;
	logic [3:0]      cur_phase;
	logic [OffW-1:0] cur_off;
	logic [3:0]      nxt_phase;
	logic [OffW-1:0] nxt_off;
	logic [OffW:0]   off_inc;
	logic            is_break;

	// Restart applies before the byte is looked at
	assign cur_phase = restart ? PH_START : phase_q;
	assign cur_off   = restart ? '0 : value_offset_q;
	assign off_inc   = {1'b0, cur_off} + {{OffW{1'b0}}, 1'b1};
	assign is_break  = (data_byte == CH_CR) || (data_byte == CH_LF);

	// Decode the byte against the current phase
	always_comb begin
		nxt_phase = cur_phase;
		nxt_off   = cur_off;
		result    = '0;
		unique case (cur_phase)
			PH_START: begin
				if (!is_break) begin
					nxt_phase   = PH_KEY;
					result.role = ROLE_KEY;
				end
			end
			PH_KEY: begin
				if (data_byte == CH_COLON) begin
					nxt_phase       = PH_COLON;
					result.key_done = 1'b1;
				end else if (is_break) begin
					nxt_phase          = PH_ERROR;
					result.parse_error = 1'b1;
					result.error_kind  = ERR_KEY_BREAK;
				end else begin
					result.role = ROLE_KEY;
				end
			end
			PH_COLON: begin
				if (data_byte == CH_SPACE) begin
					nxt_phase = PH_SPACE;
				end else begin
					nxt_phase          = PH_ERROR;
					result.parse_error = 1'b1;
					result.error_kind  = ERR_NO_SPACE;
				end
			end
			PH_SPACE: begin
				nxt_phase   = PH_VALUE;
				nxt_off     = '0;
				result.role = ROLE_VALUE;
			end
			PH_VALUE: begin
				if (data_byte == CH_CR) begin
					nxt_phase = PH_CR;
				end else if (off_inc > {1'b0, max_value_offset}) begin
					nxt_phase          = PH_ERROR;
					result.parse_error = 1'b1;
					result.error_kind  = ERR_TOO_LONG;
				end else begin
					nxt_off     = off_inc[OffW-1:0];
					result.role = ROLE_VALUE;
				end
			end
			PH_CR: begin
				if (data_byte == CH_LF) begin
					nxt_phase         = PH_LF;
					result.field_done = 1'b1;
				end else begin
					nxt_phase          = PH_ERROR;
					result.parse_error = 1'b1;
					result.error_kind  = ERR_CR_NO_LF;
				end
			end
			PH_LF: begin
				if (data_byte == CH_CR) begin
					nxt_phase = PH_END_CR;
				end else begin
					nxt_phase   = PH_KEY;
					result.role = ROLE_KEY;
				end
			end
			PH_END_CR: begin
				if (data_byte == CH_LF) begin
					nxt_phase           = PH_DONE;
					result.headers_done = 1'b1;
				end else begin
					nxt_phase          = PH_ERROR;
					result.parse_error = 1'b1;
					result.error_kind  = ERR_END_CR;
				end
			end
			PH_DONE: begin
				nxt_phase = PH_DONE;
			end
			default: begin
				nxt_phase = PH_ERROR;
			end
		endcase
	end

	// Advance the state once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_START;
			value_offset_q <= '0;
		end else if (fire) begin
			phase_q        <= nxt_phase;
			value_offset_q <= nxt_off;
		end
	end

	`HHLP_ASSERT(a_sticky_end, clk, arst_n, (fire && !restart && (phase_q == PH_DONE || phase_q == PH_ERROR)) |=> (phase_q == $past(phase_q)), "done or error phase left without restart")
	`HHLP_ASSERT(a_error_quiet, clk, arst_n, (fire && result.parse_error) |-> (result.role == ROLE_NONE && !result.key_done && !result.field_done && !result.headers_done), "error byte carries a role or done flag")
	`HHLP_ASSERT_ALWAYS(a_kind_match, clk, fire |-> (result.parse_error == (result.error_kind != ERR_NONE)), "error kind disagrees with error flag")
	`HHLP_ASSERT(a_off_limit, clk, arst_n, (fire && phase_q == PH_VALUE && !restart && result.role == ROLE_VALUE) |=> (value_offset_q <= $past(max_value_offset)), "value offset passed the limit")

endmodule

>>> design/http_header_line_parser.sv
// Top level of the HTTP header line parser: input register, parse FSM, result register.
// Depends on hhlp_pkg, hhlp_cfg and hhlp_fsm.
//
//  port group   direction  beat contents
//  in_*         in         data_byte, restart
//  out_*        out        role, key_done, field_done, headers_done, parse_error, error_kind
//  APB          in/out     max_value_offset register at address 0
//
// One byte per cycle sustained while out_stall is low; each byte passes the input register, then the result register.
// The rate is set by the single phase register that each byte reads and updates.
// Reset clears the phase, the offset, both valid flags and loads the limit with 255.
// A stalled result holds the input register; the input side stalls only when both are full.
module http_header_line_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          restart,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    role,
	output logic                          key_done,
	output logic                          field_done,
	output logic                          headers_done,
	output logic                          parse_error,
	output logic [2:0]                    error_kind,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hhlp_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import hhlp_pkg::*;

	logic            valid_s1;
	logic [7:0]      data_s1;
	logic            restart_s1;
	logic            valid_s2;
	hhlp_result_t    res_s2;
	hhlp_result_t    res_comb;
	logic [OffW-1:0] max_off;
	logic            advance;
	logic            fire;
	logic            in_take;

	// Pipeline handshake
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	hhlp_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.max_value_offset (max_off)
	);

	hhlp_fsm u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.data_byte        (data_s1),
		.restart          (restart_s1),
		.max_value_offset (max_off),
		.result           (res_comb)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign role         = res_s2.role;
	assign key_done     = res_s2.key_done;
	assign field_done   = res_s2.field_done;
	assign headers_done = res_s2.headers_done;
	assign parse_error  = res_s2.parse_error;
	assign error_kind   = res_s2.error_kind;

endmodule
